/* rtl/cpp_pkg.sv */
// Shared types and constants for the CSI parameter parser.
package cpp_pkg;

  // Default sizing of the parser.
  localparam int MAX_PARAMS_DEF = 3;
  localparam int MAX_DIGITS_DEF = 7;

  // Fixed field widths and the number of parameter fields in a result.
  localparam int BYTE_W       = 8;
  localparam int PARAM_W      = 24;
  localparam int COUNT_W      = 2;
  localparam int NUM_REPORTED = 3;

  // Character codes the parser looks for.
  localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_SEMI = 8'h3B;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_DIGITS = 2'd1,
    STATUS_PARAMS = 2'd2,
    STATUS_END    = 2'd3
  } cpp_status_t;

  // One input item.
  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              stream_end;
  } cpp_item_t;

  // One result item.
  typedef struct packed {
    logic [BYTE_W-1:0]  final_code;
    logic [PARAM_W-1:0] first_param;
    logic [PARAM_W-1:0] second_param;
    logic [PARAM_W-1:0] third_param;
    logic [COUNT_W-1:0] param_count;
    cpp_status_t        status;
  } cpp_result_t;

endpackage

/* rtl/cpp_in_reg.sv */
// Input register stage: holds one accepted item until the parser core takes it.
module cpp_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cpp_pkg::cpp_item_t in_item,
  input  logic              take,
  output logic              item_valid,
  output cpp_pkg::cpp_item_t item
);

  logic valid;
  logic valid_next;

  // The register can load whenever it is empty or being emptied this cycle.
  assign in_ready   = !valid || take;
  assign item_valid = valid;

  always_comb begin
    valid_next = valid;
    if (in_valid && in_ready) begin
      valid_next = 1'b1;
    end else if (take) begin
      valid_next = 1'b0;
    end
  end

  // Control bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

/* rtl/cpp_core.sv */
// Parser core: digit accumulation, parameter store and result formation.
module cpp_core #(
  parameter int MAX_PARAMS = cpp_pkg::MAX_PARAMS_DEF,
  parameter int MAX_DIGITS = cpp_pkg::MAX_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  cpp_pkg::cpp_item_t  item,
  output logic                result_valid,
  output cpp_pkg::cpp_result_t result
);

  localparam int CNT_W  = $clog2(MAX_PARAMS + 1);
  localparam int DCNT_W = $clog2(MAX_DIGITS + 1);

  // Only the low 24 bits of a parameter are ever reported, and those bits
  // depend only on the low 24 bits of the accumulator.
  logic [cpp_pkg::PARAM_W-1:0] acc;
  logic [cpp_pkg::PARAM_W-1:0] acc_next;
  logic [DCNT_W-1:0]           dcount;
  logic [DCNT_W-1:0]           dcount_next;
  logic [CNT_W-1:0]            pcount;
  logic [CNT_W-1:0]            pcount_next;
  logic [cpp_pkg::PARAM_W-1:0] store      [cpp_pkg::NUM_REPORTED];
  logic [cpp_pkg::PARAM_W-1:0] store_next [cpp_pkg::NUM_REPORTED];

  logic                        is_digit;
  logic [3:0]                  digit_val;
  logic                        close_run;
  logic [cpp_pkg::PARAM_W-1:0] reported [cpp_pkg::NUM_REPORTED];

  assign is_digit  = (item.in_byte >= cpp_pkg::CHAR_ZERO) &&
                     (item.in_byte <= cpp_pkg::CHAR_NINE);
  assign digit_val = 4'(item.in_byte - cpp_pkg::CHAR_ZERO);
  assign close_run = (dcount != '0);

  // Next state and result for the item in the input register.
  always_comb begin
    acc_next     = acc;
    dcount_next  = dcount;
    pcount_next  = pcount;
    store_next   = store;
    result_valid = 1'b0;
    result       = '0;
    reported     = '{default: '0};

    if (item.stream_end) begin
      result_valid  = 1'b1;
      result.status = cpp_pkg::STATUS_END;
    end else if (is_digit) begin
      if (int'(dcount) >= MAX_DIGITS) begin
        result_valid  = 1'b1;
        result.status = cpp_pkg::STATUS_DIGITS;
      end else begin
        acc_next    = (acc << 3) + (acc << 1) + {20'b0, digit_val};
        dcount_next = dcount + DCNT_W'(1);
      end
    end else if (close_run && (int'(pcount) >= MAX_PARAMS)) begin
      result_valid  = 1'b1;
      result.status = cpp_pkg::STATUS_PARAMS;
    end else begin
      // Close a non-empty run into the next parameter slot.
      if (close_run) begin
        for (int k = 0; k < cpp_pkg::NUM_REPORTED; k++) begin
          if (int'(pcount) == k) begin
            store_next[k] = acc;
          end
        end
        pcount_next = pcount + CNT_W'(1);
        acc_next    = '0;
        dcount_next = '0;
      end
      // Anything but a separator is the final byte.
      if (item.in_byte != cpp_pkg::CHAR_SEMI) begin
        for (int k = 0; k < cpp_pkg::NUM_REPORTED; k++) begin
          if (int'(pcount_next) > k) begin
            reported[k] = store_next[k];
          end
        end
        result_valid        = 1'b1;
        result.final_code   = item.in_byte;
        result.first_param  = reported[0];
        result.second_param = reported[1];
        result.third_param  = reported[2];
        result.param_count  = cpp_pkg::COUNT_W'(pcount_next);
        result.status       = cpp_pkg::STATUS_OK;
      end
    end

    // Every result ends the sequence.
    if (result_valid) begin
      acc_next    = '0;
      dcount_next = '0;
      pcount_next = '0;
    end
  end

  // Sequence state; stored parameters are qualified by the count.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= '0;
      dcount <= '0;
      pcount <= '0;
    end else if (fire) begin
      acc    <= acc_next;
      dcount <= dcount_next;
      pcount <= pcount_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      store <= store_next;
    end
  end

endmodule

/* rtl/cpp_out_reg.sv */
// Result register: holds one result item until the downstream side takes it.
module cpp_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  cpp_pkg::cpp_result_t load_data,
  output logic                 space,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cpp_pkg::cpp_result_t out_data
);

  logic valid;
  logic valid_next;

  // Room for a new result when empty or when the held one leaves now.
  assign space     = !valid || out_ready;
  assign out_valid = valid;

  always_comb begin
    valid_next = valid;
    if (load) begin
      valid_next = 1'b1;
    end else if (out_ready) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

/* rtl/csi_parameter_parser.sv */
// CSI parameter parser: takes one byte of a control sequence body per item
// and emits one result per final byte, error or stream end. Throughput is
// one item per clock cycle while the downstream side takes results. A byte
// is held in the input register, and its result is loaded into the result
// register when that register has room. While a result waits in the result
// register, the input register still takes one more item and then the
// input stalls.
// The byte is decoded and the digit accumulator (a multiply by ten and add)
// updated combinationally between those two registers. Up to MAX_DIGITS
// digits per parameter and MAX_PARAMS parameters per sequence are accepted;
// the first three parameters are reported in 24 bits each. Errors return
// zeros in all data fields with the error in the status.
module csi_parameter_parser #(
  parameter int MAX_PARAMS = cpp_pkg::MAX_PARAMS_DEF,
  parameter int MAX_DIGITS = cpp_pkg::MAX_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic [0:0]  s_tuser,   // [0] stream_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // [7:0] final_code, [31:8] first_param,
                                 // [55:32] second_param, [79:56] third_param,
                                 // [81:80] param_count, [87:82] zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  cpp_pkg::cpp_item_t   in_item;
  cpp_pkg::cpp_item_t   item;
  logic                 item_valid;
  logic                 space;
  logic                 fire;
  logic                 result_valid;
  cpp_pkg::cpp_result_t result;
  cpp_pkg::cpp_result_t out_data;

  assign in_item.in_byte    = s_tdata;
  assign in_item.stream_end = s_tuser[0];

  // The core consumes the held item when the result register has room.
  assign fire = item_valid && space;

  cpp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  cpp_core #(
    .MAX_PARAMS (MAX_PARAMS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .item         (item),
    .result_valid (result_valid),
    .result       (result)
  );

  cpp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (fire && result_valid),
    .load_data (result),
    .space     (space),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  // Pack the result fields onto the bus.
  assign m_tdata = {6'b0, out_data.param_count, out_data.third_param,
                    out_data.second_param, out_data.first_param,
                    out_data.final_code};
  assign m_tuser = out_data.status;

endmodule

/* verif/tb_csi_parameter_parser.sv */
// Self-checking testbench for the CSI parameter parser, directed table and random sequences.
module tb_csi_parameter_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_ITEMS    = 1550;
  localparam int IDLE_PCT       = 36;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int QUIET_FROM     = 700;
  localparam int QUIET_TO       = 1000;

  // One row of stimulus; typed rows carry a result written in by hand.
  typedef struct packed {
    logic [7:0]           data_byte;
    logic                 end_flag;
    logic                 typed;
    cpp_pkg::cpp_result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] in_byte
  logic [0:0]  s_tuser;   // [0] stream_end
  logic        m_tvalid;
  logic        m_tready;
  logic [87:0] m_tdata;   // [7:0] final_code, [31:8] first_param, [55:32] second_param,
                          // [79:56] third_param, [81:80] param_count, [87:82] zero
  logic [1:0]  m_tuser;   // [1:0] status

  // Parser state as the predictor sees it.
  int unsigned acc_value;
  int unsigned run_digits;
  int unsigned closed_params;
  logic [31:0] param_vals [cpp_pkg::MAX_PARAMS_DEF];

  cpp_pkg::cpp_result_t pending_results [$];
  stim_row_t            stim_table [$];
  stim_row_t            cur_row;

  int  fails;
  int  items_sent;
  int  results_checked;
  int  status_seen [4];
  int  stuck_cycles;
  int  stall_left;
  bit  quiet_mode;
  bit  hold_request;

  csi_parameter_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Free-running clock, 8 ns period.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic bit is_digit(input logic [7:0] b);
    return (b >= cpp_pkg::CHAR_ZERO) && (b <= cpp_pkg::CHAR_NINE);
  endfunction

  // Every result, ok or error, leaves the parser with nothing collected.
  function automatic void clear_parse_state();
    acc_value     = 0;
    run_digits    = 0;
    closed_params = 0;
    for (int k = 0; k < cpp_pkg::MAX_PARAMS_DEF; k++) begin
      param_vals[k] = '0;
    end
  endfunction

  // Advances the parser state by one byte and returns the result it causes, if any.
  task automatic predict_parse(input logic [7:0] b, input logic ended,
                               output bit produced, output cpp_pkg::cpp_result_t r);
    r        = '0;
    produced = 1'b0;
    if (ended) begin
      r.status = cpp_pkg::STATUS_END;
      produced = 1'b1;
    end else if (is_digit(b)) begin
      if (run_digits >= cpp_pkg::MAX_DIGITS_DEF) begin
        r.status = cpp_pkg::STATUS_DIGITS;
        produced = 1'b1;
      end else begin
        acc_value  = acc_value * 10 + (b - cpp_pkg::CHAR_ZERO);
        run_digits = run_digits + 1;
      end
    end else if (run_digits > 0 && closed_params >= cpp_pkg::MAX_PARAMS_DEF) begin
      r.status = cpp_pkg::STATUS_PARAMS;
      produced = 1'b1;
    end else begin
      // A semicolon or the final byte closes a non-empty run.
      if (run_digits > 0) begin
        param_vals[closed_params] = acc_value;
        closed_params = closed_params + 1;
        acc_value     = 0;
        run_digits    = 0;
      end
      if (b != cpp_pkg::CHAR_SEMI) begin
        r.final_code   = b;
        r.first_param  = (closed_params > 0) ? param_vals[0][cpp_pkg::PARAM_W-1:0] : '0;
        r.second_param = (closed_params > 1) ? param_vals[1][cpp_pkg::PARAM_W-1:0] : '0;
        r.third_param  = (closed_params > 2) ? param_vals[2][cpp_pkg::PARAM_W-1:0] : '0;
        r.param_count  = closed_params[cpp_pkg::COUNT_W-1:0];
        r.status       = cpp_pkg::STATUS_OK;
        produced       = 1'b1;
      end
    end
    if (produced) begin
      clear_parse_state();
    end
  endtask

  function automatic void add_row(input logic [7:0] b, input logic e,
                                  input logic typed = 1'b0,
                                  input logic [7:0] code = 8'h00,
                                  input logic [cpp_pkg::PARAM_W-1:0] p1 = '0,
                                  input logic [cpp_pkg::COUNT_W-1:0] cnt = '0,
                                  input cpp_pkg::cpp_status_t st = cpp_pkg::STATUS_OK);
    stim_row_t row;
    row.data_byte          = b;
    row.end_flag           = e;
    row.typed              = typed;
    row.want               = '0;
    row.want.final_code    = code;
    row.want.first_param   = p1;
    row.want.param_count   = cnt;
    row.want.status        = st;
    stim_table.push_back(row);
  endfunction

  function automatic void check_field(input string name,
                                      input logic [cpp_pkg::PARAM_W-1:0] want,
                                      input logic [cpp_pkg::PARAM_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  // Offers one item from the falling edge on and returns at the edge that takes it.
  task automatic send_item(input stim_row_t row);
    @(negedge clk);
    while (!quiet_mode && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= row.data_byte;
    s_tuser  <= row.end_flag;
    cur_row  = row;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic send_plain(input logic [7:0] b, input logic e);
    stim_row_t row;
    row           = '0;
    row.data_byte = b;
    row.end_flag  = e;
    send_item(row);
  endtask

  // A mostly well-formed sequence: digit runs, separators, then a final byte.
  task automatic send_random_sequence();
    int         n_runs;
    int         n_dig;
    bit         all_nines;
    logic [7:0] fb;
    n_runs = ($urandom_range(14) == 0) ? cpp_pkg::MAX_PARAMS_DEF + 1
                                       : $urandom_range(cpp_pkg::MAX_PARAMS_DEF);
    for (int k = 0; k < n_runs; k++) begin
      if ($urandom_range(9) == 0) begin
        send_plain(cpp_pkg::CHAR_SEMI, 1'b0);
      end
      n_dig = ($urandom_range(19) == 0) ? cpp_pkg::MAX_DIGITS_DEF + 1
                                        : $urandom_range(cpp_pkg::MAX_DIGITS_DEF, 1);
      all_nines = ($urandom_range(9) == 0);
      for (int d = 0; d < n_dig; d++) begin
        send_plain(all_nines ? cpp_pkg::CHAR_NINE
                             : cpp_pkg::CHAR_ZERO + 8'($urandom_range(9)), 1'b0);
      end
      if (k < n_runs - 1 || $urandom_range(3) == 0) begin
        send_plain(cpp_pkg::CHAR_SEMI, 1'b0);
      end
    end
    if ($urandom_range(24) == 0) begin
      send_plain(8'($urandom_range(255)), 1'b1);
    end else begin
      do fb = 8'($urandom_range(255)); while (is_digit(fb) || fb == cpp_pkg::CHAR_SEMI);
      send_plain(fb, 1'b0);
    end
  endtask

  // Prediction on every accepted item and checking of every accepted result.
  always @(posedge clk) begin : result_check
    cpp_pkg::cpp_result_t want;
    cpp_pkg::cpp_result_t got;
    bit                   produced;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_parse(s_tdata, s_tuser[0], produced, want);
        if (cur_row.typed) begin
          pending_results.push_back(cur_row.want);
        end else if (produced) begin
          pending_results.push_back(want);
        end
      end
      if (m_tvalid && m_tready) begin
        got.final_code   = m_tdata[7:0];
        got.first_param  = m_tdata[31:8];
        got.second_param = m_tdata[55:32];
        got.third_param  = m_tdata[79:56];
        got.param_count  = m_tdata[81:80];
        got.status       = cpp_pkg::cpp_status_t'(m_tuser);
        results_checked++;
        status_seen[m_tuser]++;
        if (pending_results.size() == 0) begin
          $error("result with no item waiting for it: code %0d, status %0d",
                 got.final_code, got.status);
          fails++;
        end else begin
          want = pending_results.pop_front();
          check_field("final_code", cpp_pkg::PARAM_W'(want.final_code),
                      cpp_pkg::PARAM_W'(got.final_code));
          check_field("first_param", want.first_param, got.first_param);
          check_field("second_param", want.second_param, got.second_param);
          check_field("third_param", want.third_param, got.third_param);
          check_field("param_count", cpp_pkg::PARAM_W'(want.param_count),
                      cpp_pkg::PARAM_W'(got.param_count));
          check_field("status", cpp_pkg::PARAM_W'(want.status),
                      cpp_pkg::PARAM_W'(got.status));
          check_field("tdata padding", '0, cpp_pkg::PARAM_W'(m_tdata[87:82]));
        end
      end
    end
  end

  // Result side: random back-pressure, one long hold when asked, none while quiet.
  initial begin
    m_tready   = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_tready   <= 1'b0;
        stall_left = stall_left - 1;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HOLD_CYCLES - 1;
        m_tready     <= 1'b0;
      end else begin
        m_tready <= quiet_mode || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Ends the run if nothing moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Main sequence: reset, directed table, random sequences, drain.
  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = '0;
    cur_row      = '0;
    fails        = 0;
    items_sent   = 0;
    results_checked = 0;
    quiet_mode   = 1'b0;
    hold_request = 1'b0;
    for (int k = 0; k < 4; k++) begin
      status_seen[k] = 0;
    end
    clear_parse_state();

    // Stream end from idle, with every bit of the ignored byte set.
    add_row(8'hFF, 1'b1, 1'b1, 8'h00, '0, '0, cpp_pkg::STATUS_END);
    // A zero byte is an ordinary final code with nothing collected.
    add_row(8'h00, 1'b0, 1'b1, 8'h00, '0, '0, cpp_pkg::STATUS_OK);
    // Largest value a run of MAX_DIGITS digits can give, closed by the top byte.
    repeat (cpp_pkg::MAX_DIGITS_DEF) add_row(cpp_pkg::CHAR_NINE, 1'b0);
    add_row(8'hFF, 1'b0, 1'b1, 8'hFF, 24'd9999999, 2'd1, cpp_pkg::STATUS_OK);
    // One digit too many in a run.
    for (int k = 0; k <= cpp_pkg::MAX_DIGITS_DEF; k++) begin
      add_row(cpp_pkg::CHAR_ZERO + 8'(k), 1'b0, k == cpp_pkg::MAX_DIGITS_DEF,
              8'h00, '0, '0, cpp_pkg::STATUS_DIGITS);
    end
    // One parameter too many, found when the final byte closes the fourth run.
    for (int k = 1; k <= cpp_pkg::MAX_PARAMS_DEF; k++) begin
      add_row(cpp_pkg::CHAR_ZERO + 8'(k), 1'b0);
      add_row(cpp_pkg::CHAR_SEMI, 1'b0);
    end
    add_row(cpp_pkg::CHAR_ZERO + 8'd4, 1'b0);
    add_row(8'h78, 1'b0, 1'b1, 8'h00, '0, '0, cpp_pkg::STATUS_PARAMS);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) begin
      send_item(stim_table[i]);
    end

    // The result side holds off at the start so that the parser fills and stalls.
    hold_request = 1'b1;
    while (items_sent < TOTAL_ITEMS) begin
      quiet_mode = (items_sent >= QUIET_FROM) && (items_sent < QUIET_TO);
      if ($urandom_range(7) == 0) begin
        repeat ($urandom_range(6, 1)) begin
          send_plain(8'($urandom_range(255)), $urandom_range(9) == 0);
        end
      end else begin
        send_random_sequence();
      end
    end
    quiet_mode = 1'b0;

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      fails++;
    end

    $display("Sent %0d bytes and checked %0d results: %0d ok, %0d digit overflows,",
             items_sent, results_checked, status_seen[cpp_pkg::STATUS_OK],
             status_seen[cpp_pkg::STATUS_DIGITS]);
    $display("%0d parameter overflows and %0d stream ends, with one long output stall.",
             status_seen[cpp_pkg::STATUS_PARAMS], status_seen[cpp_pkg::STATUS_END]);
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/cpp_pkg.sv
rtl/cpp_in_reg.sv
rtl/cpp_core.sv
rtl/cpp_out_reg.sv
rtl/csi_parameter_parser.sv
verif/tb_csi_parameter_parser.sv
